/* src/sbde_pkg.sv */
// ----------------------------------------------------------------------------
// sbde_pkg
// shared constants, codes and types of the sparse bit-row dedup encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbde_pkg;

  localparam int unsigned RowBits   = 32;
  localparam int unsigned WinDepth  = 7;
  localparam int unsigned IdxW      = 12;
  localparam int unsigned CwW       = 4;
  localparam int unsigned PosW      = $clog2(RowBits + 1);
  localparam int unsigned KindW     = 2;
  localparam int unsigned OutDataW  = 16;
  localparam logic [IdxW-1:0] IndexCap = IdxW'(4095);
  localparam logic [CwW-1:0]  CwReset  = CwW'(8);

  typedef enum logic [KindW-1:0] {
    KIND_ZERO  = 2'd0,
    KIND_COPY  = 2'd1,
    KIND_DELTA = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZERO,
    ST_COPY,
    ST_BITS
  } emit_state_e;

  typedef struct packed {
    logic [RowBits-1:0] row;
    logic [IdxW-1:0]    index;
    logic               source;
  } win_entry_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] origin;
  } hit_t;

  typedef struct packed {
    emit_state_e        mode;
    logic [RowBits-1:0] row;
    logic [IdxW-1:0]    origin;
  } load_t;

endpackage

`default_nettype wire

/* src/sbde_cell.sv */
// ----------------------------------------------------------------------------
// sbde_cell
// one window slot: holds a past row, compares it and passes it on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbde_cell
  import sbde_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                shift_i,
  input  wire                clr_i,
  input  wire                en_i,
  input  wire  [RowBits-1:0] cmp_row_i,
  input  win_entry_t         ent_i,
  output win_entry_t         ent_o,
  input  hit_t               hit_i,
  output hit_t               hit_o
);

  logic               source_q, source_d;
  logic [RowBits-1:0] row_q, row_d;
  logic [IdxW-1:0]    index_q, index_d;
  logic               match;

  assign match = en_i && source_q && (row_q == cmp_row_i);

  // farther cells win, so an upstream hit passes through
  always_comb begin
    hit_o.found  = hit_i.found || match;
    hit_o.origin = hit_i.found ? hit_i.origin : index_q;
  end

  always_comb begin
    source_d = source_q;
    row_d    = row_q;
    index_d  = index_q;
    if (shift_i) begin
      source_d = clr_i ? 1'b0 : ent_i.source;
      row_d    = ent_i.row;
      index_d  = ent_i.index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= 1'b0;
    end else begin
      source_q <= source_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    index_q <= index_d;
  end

  assign ent_o.row    = row_q;
  assign ent_o.index  = index_q;
  assign ent_o.source = source_q;

endmodule

`default_nettype wire

/* src/sbde_emit.sv */
// ----------------------------------------------------------------------------
// sbde_emit
// result sequencer: walks the set bits of a row and drives the output beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbde_emit
  import sbde_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  load_t               load_data_i,
  output logic                idle_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [KindW-1:0]    out_kind_o,
  output logic [IdxW-1:0]     out_value_o,
  output logic                out_last_o
);

  emit_state_e        state_q, state_d;
  logic [RowBits-1:0] rem_q, rem_d;
  logic [PosW-1:0]    prev_q, prev_d;
  logic [IdxW-1:0]    origin_q, origin_d;
  logic               valid_q, valid_d;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [IdxW-1:0]    value_q, value_d;
  logic               last_q, last_d;
  logic               advance;
  logic [PosW-1:0]    low_pos;

  assign advance = (state_q != ST_IDLE) && (!valid_q || out_ready_i);

  // lowest set bit, as a 1-based position
  always_comb begin
    low_pos = '0;
    for (int k = RowBits - 1; k >= 0; k--) begin
      if (rem_q[k]) begin
        low_pos = PosW'(k + 1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (load_i) begin
          state_d = load_data_i.mode;
        end
      end
      ST_ZERO, ST_COPY: begin
        if (advance) begin
          state_d = ST_IDLE;
        end
      end
      ST_BITS: begin
        if (advance && (rem_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rem_d    = rem_q;
    prev_d   = prev_q;
    origin_d = origin_q;
    kind_d   = kind_q;
    value_d  = value_q;
    last_d   = last_q;
    valid_d  = valid_q && !out_ready_i;
    if (load_i) begin
      rem_d    = load_data_i.row;
      prev_d   = '0;
      origin_d = load_data_i.origin;
    end
    if (advance) begin
      valid_d = 1'b1;
      case (state_q)
        ST_ZERO: begin
          kind_d  = KIND_ZERO;
          value_d = '0;
          last_d  = 1'b1;
        end
        ST_COPY: begin
          kind_d  = KIND_COPY;
          value_d = origin_q;
          last_d  = 1'b1;
        end
        ST_BITS: begin
          if (rem_q != '0) begin
            kind_d  = KIND_DELTA;
            value_d = IdxW'(low_pos - prev_q);
            last_d  = 1'b0;
            rem_d   = rem_q & (rem_q - RowBits'(1));
            prev_d  = low_pos;
          end else begin
            kind_d  = KIND_END;
            value_d = '0;
            last_d  = 1'b1;
          end
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    prev_q   <= prev_d;
    origin_q <= origin_d;
    kind_q   <= kind_d;
    value_q  <= value_d;
    last_q   <= last_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_value_o = value_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

/* src/sparse_bitrow_dedup_encoder_core.sv */
// ----------------------------------------------------------------------------
// sparse_bitrow_dedup_encoder_core
// encodes bit rows as zero marks, copy marks or set-bit position deltas
// ----------------------------------------------------------------------------
// s_axis carries one 32-bit row per beat in tdata; tuser high starts a new
// block (row index back to 0, window cleared). m_axis gives result beats:
// tdata[1:0] kind, tdata[13:2] value, tlast on the final beat of a row.
// cfg_we_i / cfg_wdata_i write copy_window; the user must write it only while
// the block is idle, as the block does not enforce this. a row is accepted only
// when the sequencer is free; the window search runs in the accept cycle along
// a chain of seven cells. accept registers the sequencer state, and the state
// then fills the output register with the first result beat. throughput: one
// result beat per cycle while m_axis_tready is high; zero and copy rows give
// one beat, a row with n set bits n deltas and an end beat. reset clears the
// window, the row index, the sequencer and the output valid; copy_window returns to 8.
// when m_axis_tready is low the output beat holds and the sequencer waits,
// so s_axis_tready stays low until the row's last beat has been produced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_bitrow_dedup_encoder_core
  import sbde_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [CwW-1:0]      cfg_wdata_i,     // copy_window
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [RowBits-1:0]  s_axis_tdata,    // row_bits
  input  wire                 s_axis_tuser,    // block_start
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,    // kind[1:0], value[13:2], zero pad
  output logic                m_axis_tlast     // last
);

  logic [CwW-1:0]  copy_window_q, copy_window_d;
  logic [IdxW-1:0] row_count_q, row_count_d;
  logic            accept;
  logic            idle;
  logic [IdxW-1:0] my_index;
  logic [WinDepth-1:0] en;
  win_entry_t      ent [WinDepth+1];
  hit_t            hit [WinDepth+1];
  load_t           load_data;
  logic [KindW-1:0] out_kind;
  logic [IdxW-1:0]  out_value;

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && idle;
  assign my_index      = s_axis_tuser ? '0 : row_count_q;

  always_comb begin
    copy_window_d = cfg_we_i ? cfg_wdata_i : copy_window_q;
    row_count_d   = row_count_q;
    if (accept) begin
      row_count_d = (my_index < IndexCap) ? my_index + IdxW'(1) : my_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_window_q <= CwReset;
      row_count_q   <= '0;
    end else begin
      copy_window_q <= copy_window_d;
      row_count_q   <= row_count_d;
    end
  end

  always_comb begin
    for (int d = 0; d < WinDepth; d++) begin
      en[d] = ({1'b0, copy_window_q} > (CwW + 1)'(d + 1)) && !s_axis_tuser;
    end
  end

  assign hit[WinDepth] = '0;

  assign ent[0].row    = s_axis_tdata;
  assign ent[0].index  = my_index;
  assign ent[0].source = (s_axis_tdata != '0) && !hit[0].found;

  for (genvar d = 0; d < WinDepth; d++) begin : g_cell
    sbde_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (accept),
      .clr_i     (s_axis_tuser && (d > 0)),
      .en_i      (en[d]),
      .cmp_row_i (s_axis_tdata),
      .ent_i     (ent[d]),
      .ent_o     (ent[d+1]),
      .hit_i     (hit[d+1]),
      .hit_o     (hit[d])
    );
  end

  always_comb begin
    load_data.row    = s_axis_tdata;
    load_data.origin = hit[0].origin;
    if (s_axis_tdata == '0) begin
      load_data.mode = ST_ZERO;
    end else if (hit[0].found) begin
      load_data.mode = ST_COPY;
    end else begin
      load_data.mode = ST_BITS;
    end
  end

  sbde_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .load_data_i (load_data),
    .idle_o      (idle),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OutDataW - KindW - IdxW){1'b0}}, out_value, out_kind};

endmodule

`default_nettype wire
